// ===== sv/signed_magnitude_moving_average_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed magnitude moving average core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_MAGNITUDE_MOVING_AVERAGE_CORE_MACROS_SVH
`define SIGNED_MAGNITUDE_MOVING_AVERAGE_CORE_MACROS_SVH

// same-cycle implication
`define SMMA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/smma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smma_pkg
// Shared types and constants of the signed magnitude moving average core.
// ----------------------------------------------------------------------------
package smma_pkg;

  localparam int RING_DEPTH_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int SUM_EXTRA       = 10;
  localparam int HW_W            = 9;
  localparam int CNT_W           = 11;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;

  localparam logic [HW_W-1:0]   HW_RESET = 9'd500;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [CFG_AW-3:0] REG_HALF_WINDOW = '0;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_EVAL,
    FE_BACK,
    FE_SIGN
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic neg;
    logic last;
  } job_ctrl_t;

  typedef struct packed {
    logic idle;
    logic drained;
  } front_stat_t;

endpackage

// ===== sv/signed_magnitude_moving_average_core.sv =====
// An emitting item passes FE_EVAL, FE_BACK and FE_SIGN, the job queue, the 34-step
// serial divider and BK_DONE before out_tvalid; the front takes new items while the
// divider works, until the job queue is full; items that emit nothing pass only FE_EVAL.
// Reset: synchronous active-low rst_n clears pointers, counts, sum and queue;
// half_window returns to 500; ring contents are kept and need no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_magnitude_moving_average_core
// Centered moving average of sample magnitude with the sign of the center
// sample, stream in and out, APB register for the half window.
// ----------------------------------------------------------------------------
`include "signed_magnitude_moving_average_core_macros.svh"

module signed_magnitude_moving_average_core #(
  parameter int RING_DEPTH  = smma_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = smma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [smma_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [smma_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [smma_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // sample
  input  logic                                in_tuser,   // op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,  // value
  output logic                                out_tlast
);
  import smma_pkg::*;

  localparam int TD_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SUM_W = SAMPLE_BITS + SUM_EXTRA;
  localparam int JOB_W = $bits(job_ctrl_t) + CNT_W + SUM_W;

  logic [HW_W-1:0]  hw_r, hw_nxt;
  logic             cfg_wr;

  logic             fifo_push, fifo_pop, fifo_full, fifo_empty;
  logic [JOB_W-1:0] fifo_din, fifo_dout;
  logic [SUM_W-1:0] fe_sum, bk_sum;
  logic [CNT_W-1:0] fe_count, bk_count;
  job_ctrl_t        fe_ctrl, bk_ctrl;
  front_stat_t      fe_stat;
  logic [SAMPLE_BITS-1:0] out_value;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_AW-1:2] == REG_HALF_WINDOW);
  assign cfg_prdata = (cfg_psel && (cfg_paddr[CFG_AW-1:2] == REG_HALF_WINDOW)) ?
                      CFG_DW'(hw_r) : '0;

  always_comb begin
    hw_nxt = cfg_wr ? cfg_pwdata[HW_W-1:0] : hw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= HW_RESET;
    end else begin
      hw_r <= hw_nxt;
    end
  end

  smma_front #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .half_window(hw_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .push       (fifo_push),
    .full       (fifo_full),
    .job_sum    (fe_sum),
    .job_count  (fe_count),
    .job_ctrl   (fe_ctrl),
    .stat       (fe_stat)
  );

  assign fifo_din = {fe_ctrl, fe_count, fe_sum};

  smma_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fifo_push),
    .din  (fifo_din),
    .pop  (fifo_pop),
    .dout (fifo_dout),
    .full (fifo_full),
    .empty(fifo_empty)
  );

  assign bk_sum   = fifo_dout[SUM_W-1:0];
  assign bk_count = fifo_dout[SUM_W+CNT_W-1:SUM_W];
  assign bk_ctrl  = job_ctrl_t'(fifo_dout[JOB_W-1:SUM_W+CNT_W]);

  smma_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (fifo_empty),
    .pop      (fifo_pop),
    .job_sum  (bk_sum),
    .job_count(bk_count),
    .job_ctrl (bk_ctrl),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_value(out_value),
    .out_last (out_tlast)
  );

  assign out_tdata = TD_W'(out_value);

  `SMMA_ASSERT_IMPLY(a_push_not_full, fifo_push, !fifo_full, "job pushed into full queue")
  `SMMA_ASSERT_IMPLY(a_pop_not_empty, fifo_pop, !fifo_empty, "job popped from empty queue")
  `SMMA_ASSERT_NEXT(a_last_clears, fifo_push && fe_ctrl.last, fe_stat.drained, "ring not cleared after last")
  `SMMA_ASSERT_IMPLY(a_push_busy, fifo_push, !fe_stat.idle, "job pushed while front idle")

endmodule

// ===== sv/smma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smma_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/smma_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smma_fifo
// Short show-ahead job queue between the front and back sections.
// ----------------------------------------------------------------------------
module smma_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

// ===== sv/smma_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smma_front
// Accepts samples and flush ticks, keeps the sample ring and running sum,
// and queues one division job for each emitted output.
// ----------------------------------------------------------------------------
module smma_front #(
  parameter int RING_DEPTH  = smma_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = smma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic [smma_pkg::HW_W-1:0]                 half_window,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_op,
  input  logic [SAMPLE_BITS-1:0]                    in_sample,
  output logic                                      push,
  input  logic                                      full,
  output logic [SAMPLE_BITS+smma_pkg::SUM_EXTRA-1:0] job_sum,
  output logic [smma_pkg::CNT_W-1:0]                job_count,
  output smma_pkg::job_ctrl_t                       job_ctrl,
  output smma_pkg::front_stat_t                     stat
);
  import smma_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int SUM_W = SAMPLE_BITS + SUM_EXTRA;
  localparam int CMP_W = ((CNT_W > PTR_W) ? CNT_W : PTR_W) + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(RING_DEPTH);

  fe_state_t        st_r, st_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] ep_r, ep_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt;
  logic [CNT_W-1:0] wc_r, wc_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  op_t              kind_r, kind_nxt;
  logic             del_r, del_nxt;
  logic             last_r, last_nxt;

  logic [PTR_W:0]   pend_w, back_w;
  logic [PTR_W-1:0] pend, back, hm;
  logic [31:0]      red;
  logic [HW_W-1:0]  h_eff;
  logic [CMP_W-1:0] rc_x, pend_x, done, h_x;
  logic             ring_full, drop_old, emit_now, last_now, accept;

  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] s);
    return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  smma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(in_sample),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // ring occupancy, window bookkeeping
  always_comb begin
    h_eff  = (half_window == '0) ? HW_W'(1) : half_window;
    pend_w = {1'b0, wp_r} - {1'b0, ep_r} + ((wp_r < ep_r) ? DEPTH_X : '0);
    pend   = pend_w[PTR_W-1:0];
    red    = 32'(h_eff);
    for (int k = HW_W - 1; k >= 0; k--) begin
      if (red >= (32'(RING_DEPTH) << k)) begin
        red = red - (32'(RING_DEPTH) << k);
      end
    end
    hm        = red[PTR_W-1:0];
    back_w    = {1'b0, ep_r} - {1'b0, hm} + ((ep_r < hm) ? DEPTH_X : '0);
    back      = back_w[PTR_W-1:0];
    ring_full = (pend >= PTR_LAST);
    rc_x      = CMP_W'(rc_r);
    pend_x    = CMP_W'(pend);
    h_x       = CMP_W'(h_eff);
    done      = (rc_x >= pend_x) ? rc_x - pend_x : '0;
    drop_old  = (done >= h_x);
    emit_now  = (kind_r == OP_SAMPLE) ? (pend_x > h_x) : (pend != '0);
    last_now  = (kind_r == OP_FLUSH) && (pend == PTR_W'(1));
    accept    = in_valid && (st_r == FE_IDLE);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FE_IDLE: begin
        if (in_valid && ((in_op == OP_FLUSH) || !ring_full)) begin
          st_nxt = FE_EVAL;
        end
      end
      FE_EVAL: begin
        st_nxt = emit_now ? FE_BACK : FE_IDLE;
      end
      FE_BACK: begin
        st_nxt = FE_SIGN;
      end
      FE_SIGN: begin
        if (!full) begin
          st_nxt = FE_IDLE;
        end
      end
      default: st_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st_r == FE_IDLE);
    ram_we    = accept && (in_op == OP_SAMPLE) && !ring_full;
    ram_re    = 1'b0;
    ram_raddr = ep_r;
    push      = 1'b0;
    unique case (st_r)
      FE_IDLE: ;
      FE_EVAL: begin
        ram_re    = emit_now && drop_old;
        ram_raddr = back;
      end
      FE_BACK: begin
        ram_re = 1'b1;
      end
      FE_SIGN: begin
        push = !full;
      end
      default: ;
    endcase
  end

  always_comb begin
    wp_nxt   = wp_r;
    ep_nxt   = ep_r;
    rc_nxt   = rc_r;
    wc_nxt   = wc_r;
    sum_nxt  = sum_r;
    kind_nxt = kind_r;
    del_nxt  = del_r;
    last_nxt = last_r;
    unique case (st_r)
      FE_IDLE: begin
        if (accept) begin
          kind_nxt = op_t'(in_op);
          if ((in_op == OP_SAMPLE) && !ring_full) begin
            wp_nxt  = ring_next(wp_r);
            rc_nxt  = (rc_r == CNT_MAX) ? rc_r : rc_r + 1'b1;
            wc_nxt  = (wc_r == CNT_MAX) ? wc_r : wc_r + 1'b1;
            sum_nxt = sum_r + SUM_W'(mag_of(in_sample));
          end
        end
      end
      FE_EVAL: begin
        del_nxt  = drop_old;
        last_nxt = last_now;
      end
      FE_BACK: begin
        if (del_r) begin
          sum_nxt = sum_r - SUM_W'(mag_of(ram_rdata));
          if (wc_r != '0) begin
            wc_nxt = wc_r - 1'b1;
          end
        end
      end
      FE_SIGN: begin
        if (!full) begin
          ep_nxt = ring_next(ep_r);
          if (last_r) begin
            wp_nxt  = '0;
            ep_nxt  = '0;
            rc_nxt  = '0;
            wc_nxt  = '0;
            sum_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FE_IDLE;
      wp_r   <= '0;
      ep_r   <= '0;
      rc_r   <= '0;
      wc_r   <= '0;
      sum_r  <= '0;
      kind_r <= OP_SAMPLE;
      del_r  <= 1'b0;
      last_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wp_r   <= wp_nxt;
      ep_r   <= ep_nxt;
      rc_r   <= rc_nxt;
      wc_r   <= wc_nxt;
      sum_r  <= sum_nxt;
      kind_r <= kind_nxt;
      del_r  <= del_nxt;
      last_r <= last_nxt;
    end
  end

  assign job_sum       = sum_r;
  assign job_count     = wc_r;
  assign job_ctrl.neg  = ram_rdata[SAMPLE_BITS-1];
  assign job_ctrl.last = last_r;
  assign stat.idle     = (st_r == FE_IDLE);
  assign stat.drained  = (wp_r == ep_r);

endmodule

// ===== sv/smma_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smma_back
// Bit-serial restoring divide of the window sum by twice the window count,
// saturation, sign restore and the registered result stage.
// ----------------------------------------------------------------------------
module smma_back #(
  parameter int SAMPLE_BITS = smma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      empty,
  output logic                                      pop,
  input  logic [SAMPLE_BITS+smma_pkg::SUM_EXTRA-1:0] job_sum,
  input  logic [smma_pkg::CNT_W-1:0]                job_count,
  input  smma_pkg::job_ctrl_t                       job_ctrl,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [SAMPLE_BITS-1:0]                    out_value,
  output logic                                      out_last
);
  import smma_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + SUM_EXTRA;
  localparam int DIV_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0]      STEP_LAST = STEP_W'(SUM_W - 1);
  localparam logic [SAMPLE_BITS-1:0] LIMIT     = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

  bk_state_t         st_r, st_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              zero_r, zero_nxt;
  logic              neg_r, neg_nxt;
  logic              last_r, last_nxt;
  logic              ov_r, ov_nxt;
  logic [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic              lst_r, lst_nxt;

  logic [DIV_W:0]    trial;
  logic              ge, over, load;
  logic [SAMPLE_BITS-1:0] q_mag;

  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    ge    = (trial >= {1'b0, div_r});
    over  = |quo_r[SUM_W-1:SAMPLE_BITS-1];
    q_mag = zero_r ? '0 : (over ? LIMIT : quo_r[SAMPLE_BITS-1:0]);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!empty) begin
          st_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_r == STEP_LAST) begin
          st_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!ov_r || out_ready) begin
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (st_r == BK_IDLE) && !empty;
    load = (st_r == BK_DONE) && (!ov_r || out_ready);
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    zero_nxt = zero_r;
    neg_nxt  = neg_r;
    last_nxt = last_r;
    val_nxt  = val_r;
    lst_nxt  = lst_r;
    ov_nxt   = ov_r;
    if (pop) begin
      rem_nxt  = '0;
      quo_nxt  = job_sum;
      div_nxt  = {job_count, 1'b0};
      zero_nxt = (job_count == '0);
      neg_nxt  = job_ctrl.neg;
      last_nxt = job_ctrl.last;
      cnt_nxt  = '0;
    end else if (st_r == BK_DIV) begin
      rem_nxt = ge ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end
    if (load) begin
      ov_nxt  = 1'b1;
      val_nxt = neg_r ? (~q_mag + 1'b1) : q_mag;
      lst_nxt = last_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    val_r  <= val_nxt;
    lst_r  <= lst_nxt;
  end

  assign out_valid = ov_r;
  assign out_value = val_r;
  assign out_last  = lst_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed magnitude moving average core. A short
// table covers sample extremes, the zero half window, a short record under a
// wide window and a half-window change inside a record. Random records follow
// with bursty input, a stalling receiver and APB half-window changes. Every
// result is scored against a typed row value or a cycle-free smoothing mirror.
// ----------------------------------------------------------------------------
module tb_top;
  import smma_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int DW = ((SB + 7) / 8) * 8;
  localparam int PW = $clog2(RING_DEPTH_DEF);
  localparam int SW = SAMPLE_BITS_DEF + SUM_EXTRA;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_PAD = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [SW-1:0] VALUE_MAX = (SW'(1) << (SB - 1)) - 1;
  localparam logic [CFG_AW-1:0] ADDR_HALF_WINDOW = {REG_HALF_WINDOW, 2'b00};

  typedef struct packed {
    logic [SB-1:0] value;
    logic          last;
  } smoothed_t;

  typedef struct packed {
    logic          cfg;
    op_t           op;
    logic [SB-1:0] data;
    logic          typed;
    logic [SB-1:0] value;
    logic          last;
  } step_row_t;

  localparam int DIR_ROWS = 26;
  localparam step_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, OP_FLUSH,  24'h000000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'h7FFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_FLUSH,  24'h000000, 1'b1, 24'h3FFFFF, 1'b1},
    '{1'b0, OP_SAMPLE, 24'h800000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_FLUSH,  24'hFFFFFF, 1'b1, 24'hC00000, 1'b1},
    '{1'b0, OP_SAMPLE, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_FLUSH,  24'h000000, 1'b1, 24'h000000, 1'b1},
    '{1'b1, OP_SAMPLE, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'h7FFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'h800000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'h7FFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b1, OP_SAMPLE, 24'h000003, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'h000001, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'h000003, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'hFFFFFD, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'h000002, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'hFFFFFE, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_FLUSH,  24'h000000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_FLUSH,  24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_FLUSH,  24'h000000, 1'b0, 24'h000000, 1'b0},
    '{1'b1, OP_SAMPLE, 24'h0001FF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'h555555, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_SAMPLE, 24'hAAAAAA, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_FLUSH,  24'h000000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, OP_FLUSH,  24'hFFFFFF, 1'b0, 24'h000000, 1'b0}
  };

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DW-1:0]     in_tdata = '0;   // sample
  logic              in_tuser = 1'b0; // op
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DW-1:0]     out_tdata;       // value
  logic              out_tlast;

  signed_magnitude_moving_average_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // smoothing mirror
  logic [HW_W-1:0]  mirror_half;
  logic [SB-1:0]    mirror_ring [RING_DEPTH_DEF];
  logic [SW-1:0]    mirror_sum;
  logic [CNT_W-1:0] mirror_wcnt;
  logic [CNT_W-1:0] mirror_rcnt;
  logic [PW-1:0]    mirror_wr;
  logic [PW-1:0]    mirror_rd;
  smoothed_t        smoothed_q[$];

  int mismatches = 0;
  int results_seen = 0;
  int records_closed = 0;
  int half_writes = 0;
  int cycle_count = 0;
  int hold_request = 0;
  int burst_left = 0;
  bit steady = 1'b0;

  function automatic logic [SW-1:0] magnitude(input logic [SB-1:0] s);
    return s[SB-1] ? (SW'(1) << SB) - SW'(s) : SW'(s);
  endfunction

  function automatic logic [PW-1:0] occupancy();
    return mirror_wr - mirror_rd;
  endfunction

  function automatic logic [PW-1:0] active_half();
    return (mirror_half == '0) ? PW'(1) : PW'(mirror_half);
  endfunction

  function automatic void clear_window();
    mirror_sum = '0;
    mirror_wcnt = '0;
    mirror_rcnt = '0;
    mirror_wr = '0;
    mirror_rd = '0;
  endfunction

  function automatic smoothed_t emit_oldest(input logic last);
    logic [PW-1:0]    h;
    logic [PW-1:0]    pend;
    logic [CNT_W-1:0] done;
    logic [PW-1:0]    back;
    logic [SW-1:0]    q;
    smoothed_t        r;
    h = active_half();
    pend = occupancy();
    done = (mirror_rcnt >= CNT_W'(pend)) ? mirror_rcnt - CNT_W'(pend) : '0;
    if (done >= CNT_W'(h)) begin
      back = mirror_rd - h;
      mirror_sum = mirror_sum - magnitude(mirror_ring[back]);
      if (mirror_wcnt != '0) mirror_wcnt = mirror_wcnt - 1'b1;
    end
    q = (mirror_wcnt == '0) ? '0 : mirror_sum / {mirror_wcnt, 1'b0};
    if (q > VALUE_MAX) q = VALUE_MAX;
    r.value = mirror_ring[mirror_rd][SB-1] ? SB'(-q) : q[SB-1:0];
    r.last = last;
    mirror_rd = mirror_rd + 1'b1;
    return r;
  endfunction

  function automatic bit predict_smoothed(input op_t op, input logic [SB-1:0] smp);
    logic [PW-1:0] pend;
    if (op == OP_SAMPLE) begin
      if (occupancy() >= PW'(RING_DEPTH_DEF - 1)) return 1'b0;
      mirror_ring[mirror_wr] = smp;
      mirror_wr = mirror_wr + 1'b1;
      if (mirror_rcnt != CNT_MAX) mirror_rcnt = mirror_rcnt + 1'b1;
      mirror_sum = mirror_sum + magnitude(smp);
      if (mirror_wcnt != CNT_MAX) mirror_wcnt = mirror_wcnt + 1'b1;
      if (occupancy() > active_half()) begin
        smoothed_q.push_back(emit_oldest(1'b0));
        return 1'b1;
      end
      return 1'b0;
    end
    pend = occupancy();
    if (pend == '0) return 1'b0;
    if (pend == PW'(1)) begin
      smoothed_q.push_back(emit_oldest(1'b1));
      clear_window();
    end else begin
      smoothed_q.push_back(emit_oldest(1'b0));
    end
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %0s", $realtime, msg);
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    logic [SB-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s = SB'($urandom);
      5, 6: s = SB'($urandom_range(0, 255));
      7: begin
        case ($urandom_range(0, 3))
          0: s = 24'h7FFFFF;
          1: s = 24'h800000;
          2: s = 24'h000000;
          default: s = 24'hFFFFFF;
        endcase
        return s;
      end
      default: s = SB'($urandom_range(0, 65535));
    endcase
    return $urandom_range(0, 1) ? -s : s;
  endfunction

  task automatic send_item(input op_t op, input logic [SB-1:0] smp, output bit produced);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= DW'(smp);
    do @(posedge clk); while (!in_tready);
    burst_left--;
    produced = predict_smoothed(op, smp);
  endtask

  // drop valid, wait for every expected result, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic cfg_xfer(input bit wr, input logic [CFG_DW-1:0] wdata,
                          output logic [CFG_DW-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= ADDR_HALF_WINDOW;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_half();
    logic [CFG_DW-1:0] rd;
    cfg_xfer(1'b0, '0, rd);
    if (rd !== CFG_DW'(mirror_half))
      note_failure($sformatf("half_window read: expected %h, got %h",
                             CFG_DW'(mirror_half), rd));
  endtask

  task automatic write_half(input logic [HW_W-1:0] h);
    logic [CFG_DW-1:0] word;
    logic [CFG_DW-1:0] unused;
    word = $urandom;
    word[HW_W-1:0] = h;
    cfg_xfer(1'b1, word, unused);
    mirror_half = h;
    half_writes++;
    check_half();
  endtask

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    int mode;
    int span;
    logic [7:0] pattern;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      pattern = 8'($urandom) | 8'h01;
      repeat (span) begin
        @(posedge clk);
        if (hold_request != 0) begin
          out_tready <= 1'b0;
          repeat (hold_request) @(posedge clk);
          hold_request = 0;
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_tready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    smoothed_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, smoothed_q.size());
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (smoothed_q.size() == 0) begin
        note_failure($sformatf("result %h last %b with nothing outstanding",
                               out_tdata, out_tlast));
      end else begin
        want = smoothed_q.pop_front();
        if (out_tdata[SB-1:0] !== want.value)
          note_failure($sformatf("value: expected %h, got %h",
                                 want.value, out_tdata[SB-1:0]));
        if (out_tlast !== want.last)
          note_failure($sformatf("last: expected %b, got %b", want.last, out_tlast));
        if (want.last) records_closed++;
      end
    end
  end

  initial begin
    step_row_t     row;
    bit            made;
    int            counted;
    int            rec;
    int            len;
    int            shift;
    logic [HW_W-1:0] h;

    mirror_half = HW_RESET;
    clear_window();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    check_half();

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.cfg) begin
        settle();
        write_half(row.data[HW_W-1:0]);
      end else begin
        send_item(row.op, row.data, made);
        if (row.typed) begin
          if (made) void'(smoothed_q.pop_back());
          smoothed_q.push_back(smoothed_t'{row.value, row.last});
        end
      end
    end

    counted = 0;
    rec = 0;
    while (counted < RANDOM_ITEMS) begin
      settle();
      if (rec == 2 || rec == 12) begin
        h = 9'd2;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: h = HW_W'($urandom_range(1, 8));
          12, 13, 14, 15: h = HW_W'($urandom_range(9, 40));
          16: h = '0;
          17: h = 9'd1;
          18: h = 9'd511;
          default: h = HW_W'($urandom_range(400, 511));
        endcase
      end
      write_half(h);
      if (h >= 9'd100) len = $urandom_range(1, 24);
      else len = $urandom_range(1, 3 * int'(active_half()) + 24);
      steady = ($urandom_range(0, 3) == 0);
      shift = (len >= 6 && $urandom_range(0, 6) == 0) ? len / 2 : -1;
      if (rec == 2 || rec == 12) begin
        len = 60;
        hold_request = HOLD_CYCLES;
      end
      for (int k = 0; k < len; k++) begin
        if (k == shift) begin
          settle();
          write_half(HW_W'($urandom_range(0, 12)));
        end
        if (occupancy() != '0 && $urandom_range(0, 24) == 0) begin
          send_item(OP_FLUSH, SB'($urandom), made);
          counted++;
        end
        send_item(OP_SAMPLE, pick_sample(), made);
        counted++;
      end
      while (occupancy() != '0) begin
        send_item(OP_FLUSH, SB'($urandom), made);
        counted++;
      end
      if ($urandom_range(0, 4) == 0) send_item(OP_FLUSH, SB'($urandom), made);
      rec++;
    end

    settle();
    $display("Scored %0d smoothed outputs over %0d closed records, %0d half-window writes",
             results_seen, records_closed, half_writes);
    $display("Covered extremes, zero and wide windows, mid-record changes, %0d-cycle hold-offs",
             HOLD_CYCLES);
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/smma_pkg.sv
sv/smma_ram.sv
sv/smma_fifo.sv
sv/smma_front.sv
sv/smma_back.sv
sv/signed_magnitude_moving_average_core.sv
tb/tb_top.sv
